@@ design/bayer_bilinear_demosaic_defines.svh @@
// ----------------------------------------------------------------------------
// Bayer demosaic assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Widths, register indexes, reset values and shared helpers.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int ROW_W     = 12;

    localparam int HEIGHT_MAX = 4096;
    localparam int DIM_MIN    = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // [row 0 top .. 2 bottom][col 0 left .. 2 right]
    typedef pix_t [2:0][2:0] win_t;

    typedef struct packed {
        logic even_row;
        logic even_col;
        logic last;
    } site_t;

    function automatic pix_t mean2(input pix_t a, input pix_t b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[PIX_W:1];
    endfunction

endpackage

@@ design/bbd_pixel_if.sv @@
// ----------------------------------------------------------------------------
// Raw pixel channel
// Valid/ready channel carrying one raw Bayer sample per word.
// ----------------------------------------------------------------------------
interface bbd_pixel_if import bbd_pkg::*;;
    logic valid;
    logic ready;
    pix_t raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

@@ design/bbd_rgb_if.sv @@
// ----------------------------------------------------------------------------
// RGB result channel
// Valid/ready channel carrying one demosaiced pixel per word.
// ----------------------------------------------------------------------------
interface bbd_rgb_if import bbd_pkg::*;;
    logic valid;
    logic ready;
    pix_t red_out;
    pix_t green_out;
    pix_t blue_out;
    logic frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

@@ design/bayer_bilinear_demosaic.sv @@
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic (GRBG)
// Two line stores and a 3x3 window turn a raw GRBG stream into RGB for every
// interior pixel; border rows and columns give no output word.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------
//  pixel   | in  | valid/ready  | raw_pixel[7:0]
//  rgb     | out | valid/ready  | red_out, green_out, blue_out, frame_last
//  cfg     | in  | cfg_we       | cfg_index, cfg_data (frame_width/height)
//
//  One raw word per cycle while pixel.ready is high. A word's result is
//  registered in the window stage, then in the output register.
//  The line stores use one write and one read port each; the read address
//  is the next column, so the stored rows are ready when the word arrives.
//  Reset clears counters, window and valid flags; line stores are not
//  cleared. pixel.ready drops only while both the window stage and the
//  output register hold results and rgb.ready is low.
//
module bayer_bilinear_demosaic import bbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bbd_pixel_if.sink            pixel,
    bbd_rgb_if.source            rgb,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // column counter covers 0..MAX_WIDTH-1; compares run at least one bit wider
    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;
    localparam logic [CMP_W-1:0] W_MAX = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] W_MIN = CMP_W'(DIM_MIN);
    localparam logic [CFG_W-1:0] H_MAX = CFG_W'(HEIGHT_MAX);
    localparam logic [CFG_W-1:0] H_MIN = CFG_W'(DIM_MIN);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate the programmed frame size into the legal range
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] w_lim;
    logic [CFG_W-1:0] h_lim;

    assign w_ext = CMP_W'(frame_width_reg);
    assign w_lim = (w_ext < W_MIN) ? W_MIN : ((w_ext > W_MAX) ? W_MAX : w_ext);
    assign h_lim = (frame_height_reg < H_MIN) ? H_MIN :
                   ((frame_height_reg > H_MAX) ? H_MAX : frame_height_reg);

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_adv;
    logic accept;

    assign out_free    = !out_valid_reg || rgb.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign pixel.ready = !s1_valid_reg || out_free;
    assign accept      = pixel.valid && pixel.ready;

    // ---------------- position counters ----------------
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_inc;
    logic [CFG_W-1:0] row_ext;
    logic [CFG_W-1:0] row_inc;
    logic             col_wrap;
    logic             emit;
    logic             last;

    assign col_ext  = CMP_W'(col_reg);
    assign col_inc  = col_ext + CMP_W'(1);
    assign row_ext  = CFG_W'(row_reg);
    assign row_inc  = row_ext + CFG_W'(1);
    assign col_wrap = col_inc >= w_lim;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    // result for centre (row-1, col-1) once the bottom-right sample lands
    assign emit = (row_ext >= CFG_W'(2)) && (col_ext >= CMP_W'(2))
               && (row_ext < h_lim) && (col_ext < w_lim);
    assign last = (row_ext == h_lim - CFG_W'(1)) && (col_ext == w_lim - CMP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line stores ----------------
    // Read address runs one word ahead: whatever column comes next is
    // fetched at this edge. The write goes to the current column, never
    // the one being fetched, since the frame is at least four wide.
    pix_t older_rd;
    pix_t newer_rd;

    bbd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (newer_rd),
        .raddr (col_next),
        .rdata (older_rd)
    );

    bbd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pixel.raw_pixel),
        .raddr (col_next),
        .rdata (newer_rd)
    );

    // ---------------- window stage ----------------
    win_t  win_reg;
    site_t site_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= older_rd;
                win_reg[1][2] <= newer_rd;
                win_reg[2][2] <= pixel.raw_pixel;
                s1_valid_reg  <= emit;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // centre parity: centre row even when current row is odd, same for column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            site_reg.even_row <= row_reg[0];
            site_reg.even_col <= col_reg[0];
            site_reg.last     <= last;
        end
    end

    // ---------------- interpolation ----------------
    pix_t ctr;
    pix_t vert;
    pix_t horz;
    pix_t diag;
    pix_t red_calc;
    pix_t green_calc;
    pix_t blue_calc;

    assign ctr  = win_reg[1][1];
    assign vert = mean2(win_reg[0][1], win_reg[2][1]);
    assign horz = mean2(win_reg[1][0], win_reg[1][2]);
    assign diag = mean2(mean2(win_reg[0][0], win_reg[2][0]),
                        mean2(win_reg[0][2], win_reg[2][2]));

    always_comb
    begin
        case ({site_reg.even_row, site_reg.even_col})
            2'b11:   // green on a G R row
            begin
                red_calc = horz; green_calc = ctr; blue_calc = vert;
            end
            2'b10:   // red site
            begin
                red_calc = ctr; green_calc = vert; blue_calc = diag;
            end
            2'b01:   // blue site
            begin
                red_calc = diag; green_calc = vert; blue_calc = ctr;
            end
            default: // green on a B G row
            begin
                red_calc = vert; green_calc = ctr; blue_calc = horz;
            end
        endcase
    end

    // ---------------- output register ----------------
    pix_t red_reg;
    pix_t green_reg;
    pix_t blue_reg;
    logic last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rgb.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            red_reg   <= red_calc;
            green_reg <= green_calc;
            blue_reg  <= blue_calc;
            last_reg  <= site_reg.last;
        end
    end

    assign rgb.valid      = out_valid_reg;
    assign rgb.red_out    = red_reg;
    assign rgb.green_out  = green_reg;
    assign rgb.blue_out   = blue_reg;
    assign rgb.frame_last = last_reg;

endmodule

@@ design/bbd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bbd_checker.sv @@
// ----------------------------------------------------------------------------
// Bayer demosaic port checker
// Port-level properties of the demosaic, bound to the top level.
// ----------------------------------------------------------------------------
`include "bayer_bilinear_demosaic_defines.svh"

module bbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic       out_last
);

    // stalled output word holds
    `BBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_red, out_green, out_blue, out_last}), "output word changed while stalled")

    // with the output register empty the input side is never blocked
    `BBD_ASSERT_NOW(a_in_open, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")

    // a new output word must follow an earlier accepted input word
    `BBD_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "output without accepted input")

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_red   (rgb.red_out),
    .out_green (rgb.green_out),
    .out_blue  (rgb.blue_out),
    .out_last  (rgb.frame_last)
);

@@ bench/demosaic_rgb_checker.sv @@
// ----------------------------------------------------------------------------
// Demosaic RGB checker
// Watches the raw pixel, RGB and register ports, predicts every RGB word from
// the raw stream and compares the words in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module demosaic_rgb_checker import bbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bbd_pixel_if                 pixel,
    bbd_rgb_if                   rgb,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   rgb_pending,
    output int                   rgb_checked
);

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic last;
    } rgb_word_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             older_row [MAX_WIDTH];
    pix_t             newer_row [MAX_WIDTH];
    pix_t             tap [3][3];        // [0 top .. 2 bottom][0 left .. 2 right]
    int               col_pos;
    int               row_pos;
    rgb_word_t        rgb_due [$];
    int               errs;
    int               checked;

    function automatic int span_of(input logic [CFG_W-1:0] v, input int hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    // floored mean of two samples
    function automatic pix_t avg(input pix_t a, input pix_t b);
        return pix_t'((int'(a) + int'(b)) / 2);
    endfunction

    task automatic clear_model();
        int i;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (i = 0; i < 9; i++)
            tap[i / 3][i % 3] = '0;
        col_pos = 0;
        row_pos = 0;
        rgb_due.delete();
        errs    = 0;
        checked = 0;
    endtask

    task automatic predict_rgb_word(input pix_t px);
        int        w;
        int        h;
        int        idx;
        int        k;
        bit        even_row;
        bit        even_col;
        pix_t      ctr;
        pix_t      vert;
        pix_t      horz;
        pix_t      diag;
        rgb_word_t word;
        w   = span_of(width_reg, MAX_WIDTH);
        h   = span_of(height_reg, HEIGHT_MAX);
        idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        for (k = 0; k < 3; k++)
        begin
            tap[k][0] = tap[k][1];
            tap[k][1] = tap[k][2];
        end
        tap[0][2]      = older_row[idx];
        tap[1][2]      = newer_row[idx];
        tap[2][2]      = px;
        older_row[idx] = newer_row[idx];
        newer_row[idx] = px;

        if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w)
        begin
            // window centre sits one row up and one column left
            even_row = ((row_pos - 1) % 2) == 0;
            even_col = ((col_pos - 1) % 2) == 0;
            ctr  = tap[1][1];
            vert = avg(tap[0][1], tap[2][1]);
            horz = avg(tap[1][0], tap[1][2]);
            diag = avg(avg(tap[0][0], tap[2][0]), avg(tap[0][2], tap[2][2]));
            if (even_row && even_col)
            begin
                word.green = ctr;
                word.red   = horz;
                word.blue  = vert;
            end
            else if (even_row)
            begin
                word.red   = ctr;
                word.green = vert;
                word.blue  = diag;
            end
            else if (even_col)
            begin
                word.blue  = ctr;
                word.green = vert;
                word.red   = diag;
            end
            else
            begin
                word.green = ctr;
                word.blue  = horz;
                word.red   = vert;
            end
            word.last = (row_pos == h - 1) && (col_pos == w - 1);
            rgb_due.push_back(word);
        end

        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    function automatic bit field_ok(input string name, input int want, input int got);
        if (want == got)
            return 1'b1;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1'b0;
    endfunction

    task automatic check_rgb_word();
        rgb_word_t want;
        bit        ok;
        if (rgb_due.size() == 0)
        begin
            $error("RGB word with nothing expected: r=%0d g=%0d b=%0d last=%0b",
                   rgb.red_out, rgb.green_out, rgb.blue_out, rgb.frame_last);
            errs++;
            return;
        end
        want = rgb_due.pop_front();
        ok = field_ok("red_out", want.red, rgb.red_out);
        ok = field_ok("green_out", want.green, rgb.green_out) & ok;
        ok = field_ok("blue_out", want.blue, rgb.blue_out) & ok;
        ok = field_ok("frame_last", want.last, rgb.frame_last) & ok;
        if (!ok)
            errs++;
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg  = cfg_data;
                    REG_FRAME_HEIGHT: height_reg = cfg_data;
                endcase
            end
            if (rgb.valid && rgb.ready)
                check_rgb_word();
            if (pixel.valid && pixel.ready)
                predict_rgb_word(pixel.raw_pixel);
        end
        fail_count  <= errs;
        rgb_pending <= rgb_due.size();
        rgb_checked <= checked;
    end

endmodule

@@ bench/bayer_bilinear_demosaic_tb.sv @@
// ----------------------------------------------------------------------------
// Bayer demosaic testbench
// Streams raw GRBG frames of many sizes into the demosaic, with register
// writes at frame boundaries and mid-frame, random input gaps and output
// back-pressure, and leaves prediction and comparison to the RGB checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_tb import bbd_pkg::*;;

    localparam int MAX_WIDTH        = 4096;
    // a word's result passes the window stage and output register; margin on top
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int WORDS_PER_PHASE  = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bbd_pixel_if pixel_ch ();
    bbd_rgb_if   rgb_ch ();

    int fail_count;
    int rgb_pending;
    int rgb_checked;

    // idle odds in percent, per side
    int send_idle;
    int recv_idle;

    // shadow of the size registers and of the raster position, so the
    // stimulus knows where a frame ends even after a mid-frame write
    logic [CFG_W-1:0] width_set;
    logic [CFG_W-1:0] height_set;
    int               pos_col;
    int               pos_row;

    int words_sent;
    int regs_written;
    int cycle_count;
    int phase;
    int phase_start;

    bayer_bilinear_demosaic #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .rgb       (rgb_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    demosaic_rgb_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) rgb_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel_ch),
        .rgb         (rgb_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .rgb_pending (rgb_pending),
        .rgb_checked (rgb_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random back-pressure on the RGB channel
    initial
    begin
        rgb_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rgb_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // effective size after the block's saturation
    function automatic int span_of(input logic [CFG_W-1:0] v, input int hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic pix_t rand_pixel();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return pix_t'($urandom_range(255));
    endfunction

    // 0, 1, 254 or 255: extremes and the odd sums that floor
    function automatic pix_t edge_pixel();
        pix_t v;
        v = $urandom_range(1) ? 8'hFF : 8'h00;
        return v ^ pix_t'($urandom_range(1));
    endfunction

    // one register write; the wait after cfg_we drops keeps cfg_we to a single
    // nonblocking update per edge when writes come back to back
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            width_set = val;
        else
            height_set = val;
        regs_written++;
    endtask

    // drive one raw word, returns at the edge where it is taken
    task automatic send_word(input pix_t px);
        int w;
        int h;
        while ($urandom_range(99) < send_idle)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.raw_pixel <= px;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        w = span_of(width_set, MAX_WIDTH);
        h = span_of(height_set, HEIGHT_MAX);
        pos_col++;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h)
                pos_row = 0;
        end
        words_sent++;
    endtask

    task automatic send_n(input int n);
        repeat (n) send_word(rand_pixel());
    endtask

    // finish the current frame; from a boundary this sends a whole frame
    task automatic send_to_wrap();
        do
            send_word(rand_pixel());
        while (pos_col != 0 || pos_row != 0);
    endtask

    // stop the stream and let every expected word come out, plus the tail
    // of words that give no result
    task automatic settle();
        pixel_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (rgb_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_frame();
        int w;
        int h;
        // half the frames keep the sizes and run back to back
        if ($urandom_range(1) == 0)
        begin
            settle();
            if ($urandom_range(9) == 0)
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(3)));
            else if ($urandom_range(9) == 0)
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(13, 64)));
            else
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(4, 12)));
            write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 8)));
        end
        w = span_of(width_set, MAX_WIDTH);
        h = span_of(height_set, HEIGHT_MAX);
        if ($urandom_range(5) == 0)
        begin
            // mid-frame narrowing: only shrink, so every line store entry
            // read later was written in this frame
            send_n($urandom_range(w + 1, w * h - 1));
            settle();
            if ($urandom_range(1))
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(w)));
            else
                write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(h)));
        end
        send_to_wrap();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_FRAME_WIDTH;
        cfg_data           = '0;
        pixel_ch.valid     = 1'b0;
        pixel_ch.raw_pixel = '0;
        width_set          = WIDTH_RESET;
        height_set         = HEIGHT_RESET;
        pos_col            = 0;
        pos_row            = 0;
        words_sent         = 0;
        regs_written       = 0;
        send_idle          = 38;
        recv_idle          = 63;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame from sizes below range (both saturate to 4):
        // four interior words, one of each site kind, extreme samples
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        repeat (16) send_word(edge_pixel());

        // height above range saturates to 4096; after four rows cut the
        // height to 4 mid-frame, so row 4 gives nothing and wraps
        settle();
        write_reg(REG_FRAME_HEIGHT, '1);
        send_n(16);
        settle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
        send_to_wrap();

        // width 6, cut to 4 while at column 4 of row 2: that word gives
        // nothing, the last row runs at width 4 and carries frame_last
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(6));
        send_n(16);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(4));
        send_to_wrap();

        // random frames under three idle patterns
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 38;
                    recv_idle = 63;
                end
                1:
                begin
                    send_idle = 63;
                    recv_idle = 38;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE)
                random_frame();
        end

        // width above range saturates to MAX_WIDTH, height below range to 4;
        // five words into row 0 the width is cut to 4, so the next word
        // gives nothing and the rest of the frame runs at width 4
        settle();
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, '0);
        send_n(5);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(4));
        send_to_wrap();

        settle();
        $display("Streamed %0d raw words across %0d size writes: saturated, mid-frame, random.",
                 words_sent, regs_written);
        $display("Compared %0d RGB words with the bilinear prediction, %0d failed.",
                 rgb_checked, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
